>>> rtl/ppss_pkg.sv
package ppss_pkg;

    // Number of process slots held by the scorer.
    localparam int SLOT_COUNT = 16;
    localparam int SLOT_W     = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;

    // Event kinds; every code above KIND_MSYSCALL is an audit event.
    localparam logic [3:0] KIND_WRITE     = 4'd0;
    localparam logic [3:0] KIND_UNLINK    = 4'd1;
    localparam logic [3:0] KIND_EXEC      = 4'd2;
    localparam logic [3:0] KIND_CRED      = 4'd3;
    localparam logic [3:0] KIND_NETCOMMIT = 4'd4;
    localparam logic [3:0] KIND_CURVATURE = 4'd5;
    localparam logic [3:0] KIND_DNS       = 4'd6;
    localparam logic [3:0] KIND_TCP       = 4'd7;
    localparam logic [3:0] KIND_MSYSCALL  = 4'd8;

    // Configuration register indexes.
    localparam logic [2:0] REG_TIER_ONE  = 3'd0;
    localparam logic [2:0] REG_TIER_TWO  = 3'd1;
    localparam logic [2:0] REG_LOCAL_OCT = 3'd2;
    localparam logic [2:0] REG_SEND_LIM  = 3'd3;
    localparam logic [2:0] REG_CUM_LIM   = 3'd4;
    localparam logic [2:0] REG_EXFIL_LIM = 3'd5;
    localparam logic [2:0] REG_CB_EN     = 3'd6;
    localparam logic [2:0] REG_ST_EN     = 3'd7;

    // Network decisions.
    localparam logic [1:0] DEC_COMMIT = 2'd0;
    localparam logic [1:0] DEC_ABORT  = 2'd1;
    localparam logic [1:0] DEC_SYNTH  = 2'd2;

    // Tiers.
    localparam logic [1:0] TIER_NONE = 2'd0;
    localparam logic [1:0] TIER_ONE  = 2'd1;
    localparam logic [1:0] TIER_TWO  = 2'd2;

    // Reset values of the configuration registers.
    localparam logic [15:0] RST_TIER_ONE  = 16'd20;
    localparam logic [15:0] RST_TIER_TWO  = 16'd40;
    localparam logic [7:0]  RST_LOCAL_OCT = 8'd10;
    localparam logic [15:0] RST_SEND_LIM  = 16'd256;
    localparam logic [31:0] RST_CUM_LIM   = 32'd4096;
    localparam logic [31:0] RST_EXFIL_LIM = 32'd16384;

    // Unlink burst tracking.
    localparam logic [3:0] UNLINK_WINDOW = 4'd8;
    localparam logic [2:0] RUN_MAX       = 3'd7;
    localparam logic [3:0] AGE_MAX       = 4'd15;
    localparam logic [3:0] UNLINK_BASE   = 4'd2;
    localparam logic [3:0] UNLINK_CAP    = 4'd12;

    typedef struct packed {
        logic [1:0]  reply_first;
        logic [1:0]  reply_second;
        logic        set_tier_valid;
        logic [31:0] set_tier_slot;
        logic [1:0]  set_tier_value;
    } result_t;

    function automatic logic [31:0] sat_add32(input logic [31:0] a, input logic [31:0] b);
        logic [32:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[32] ? 32'hFFFF_FFFF : s[31:0];
    endfunction

    // Fixed weight of the scored kinds.
    function automatic logic [3:0] scored_weight(input logic [3:0] kind);
        logic [3:0] w;
        case (kind)
            KIND_WRITE:  w = 4'd1;
            KIND_UNLINK: w = 4'd2;
            KIND_EXEC:   w = 4'd8;
            KIND_CRED:   w = 4'd15;
            default:     w = 4'd0;
        endcase
        return w;
    endfunction

endpackage

>>> rtl/per_process_suspicion_scorer.sv
// Per-process suspicion scorer. Each event transaction (kind on s_tuser, slot and
// arguments on s_tdata) updates the state of its process slot and returns exactly
// one result transaction: a network decision or a promoted tier, plus an optional
// set-tier request. Events are registered on entry; the slot's state is read,
// updated and written back when the event leaves the input register, while the result
// is registered, so the block takes one event per cycle while the output is not held
// back and presents the result from the result register; the rate is set by that read-modify-write
// of the flip-flop slot state. Configuration writes on cfg_wen take effect at once
// and must only be issued while no event is in flight.
module per_process_suspicion_scorer (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         cfg_wen,
    input  logic [2:0]   cfg_index,
    input  logic [31:0]  cfg_wdata,
    input  logic         s_tvalid,
    output logic         s_tready,
    // slot[7:0], arg_a[39:8], arg_b[71:40], manager_slot[103:72]
    input  logic [103:0] s_tdata,
    // event_type[3:0]
    input  logic [3:0]   s_tuser,
    output logic         m_tvalid,
    input  logic         m_tready,
    // reply_first[1:0], reply_second[3:2], set_tier_valid[4],
    // set_tier_slot[36:5], set_tier_value[38:37], zero[39]
    output logic [39:0]  m_tdata
);
    import ppss_pkg::*;

    // Configuration
    logic [15:0] tier_one_reg, tier_two_reg, send_lim_reg;
    logic [7:0]  local_oct_reg;
    logic [31:0] cum_lim_reg, exfil_lim_reg;
    logic        cb_en_reg, st_en_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tier_one_reg  <= RST_TIER_ONE;
            tier_two_reg  <= RST_TIER_TWO;
            local_oct_reg <= RST_LOCAL_OCT;
            send_lim_reg  <= RST_SEND_LIM;
            cum_lim_reg   <= RST_CUM_LIM;
            exfil_lim_reg <= RST_EXFIL_LIM;
            cb_en_reg     <= 1'b0;
            st_en_reg     <= 1'b0;
        end else if (cfg_wen) begin
            unique case (cfg_index)
                REG_TIER_ONE:  tier_one_reg  <= cfg_wdata[15:0];
                REG_TIER_TWO:  tier_two_reg  <= cfg_wdata[15:0];
                REG_LOCAL_OCT: local_oct_reg <= cfg_wdata[7:0];
                REG_SEND_LIM:  send_lim_reg  <= cfg_wdata[15:0];
                REG_CUM_LIM:   cum_lim_reg   <= cfg_wdata;
                REG_EXFIL_LIM: exfil_lim_reg <= cfg_wdata;
                REG_CB_EN:     cb_en_reg     <= cfg_wdata[0];
                REG_ST_EN:     st_en_reg     <= cfg_wdata[0];
                default: ;
            endcase
        end
    end

    // Input register
    logic        in_valid_reg;
    logic [3:0]  kind_reg;
    logic [7:0]  slot_reg;
    logic [31:0] arg_a_reg, arg_b_reg, mslot_reg;
    logic        out_valid_reg;
    result_t     out_reg;
    logic        out_free, advance;

    assign out_free = !out_valid_reg || m_tready;
    assign advance  = in_valid_reg && out_free;
    assign s_tready = !in_valid_reg || out_free;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tvalid && s_tready) begin
            in_valid_reg <= 1'b1;
        end else if (advance) begin
            in_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            kind_reg  <= s_tuser;
            slot_reg  <= s_tdata[7:0];
            arg_a_reg <= s_tdata[39:8];
            arg_b_reg <= s_tdata[71:40];
            mslot_reg <= s_tdata[103:72];
        end
    end

    // Slot state
    logic [31:0] score_reg [SLOT_COUNT];
    logic [1:0]  tier_reg  [SLOT_COUNT];
    logic [31:0] wm_reg    [SLOT_COUNT];
    logic [31:0] mstore_reg[SLOT_COUNT];
    logic        prom_reg  [SLOT_COUNT];
    logic [2:0]  run_reg   [SLOT_COUNT];
    logic [3:0]  age_reg   [SLOT_COUNT];
    logic [31:0] bytes_reg [SLOT_COUNT];

    logic [SLOT_W-1:0] idx;
    logic              scored, counted;
    logic [7:0]        octet;
    logic              is_local;

    assign idx      = slot_reg[SLOT_W-1:0];
    assign counted  = {1'b0, slot_reg} < 9'(SLOT_COUNT);
    assign scored   = counted && (slot_reg != 8'd0);
    assign octet    = arg_a_reg[7:0];
    assign is_local = (octet == local_oct_reg);

    logic [31:0] score_next, wm_next, mstore_next, bytes_next;
    logic [1:0]  tier_next;
    logic        prom_next;
    logic [2:0]  run_next;
    logic [3:0]  age_next;
    result_t     res_next;

    always_comb begin
        logic        fold_en, eligible, async_hit, want_req;
        logic [31:0] fold_add, req_slot;
        logic [1:0]  target, promoted, req_tier;
        logic [3:0]  step, bonus;

        score_next  = score_reg[idx];
        tier_next   = tier_reg[idx];
        wm_next     = wm_reg[idx];
        mstore_next = mstore_reg[idx];
        prom_next   = prom_reg[idx];
        run_next    = run_reg[idx];
        age_next    = age_reg[idx];
        bytes_next  = bytes_reg[idx];
        res_next    = '0;
        fold_en     = 1'b0;
        fold_add    = {16'd0, tier_two_reg};
        eligible    = 1'b0;
        async_hit   = 1'b0;
        want_req    = 1'b0;
        req_slot    = mstore_reg[idx];
        req_tier    = TIER_TWO;
        target      = TIER_NONE;
        promoted    = TIER_NONE;
        step        = 4'd0;
        bonus       = 4'd0;

        unique case (kind_reg) inside
            KIND_WRITE, KIND_UNLINK, KIND_EXEC, KIND_CRED: begin
                if (scored) begin
                    if (mslot_reg != 32'd0) begin
                        mstore_next = mslot_reg;
                    end
                    // A falling write count means a new tenant owns the slot.
                    if (arg_b_reg != 32'd0 && arg_b_reg < wm_reg[idx]) begin
                        score_next = 32'd0;
                        tier_next  = TIER_NONE;
                        run_next   = 3'd0;
                        age_next   = 4'd0;
                        prom_next  = 1'b0;
                    end
                    wm_next = (arg_b_reg != 32'd0) ? arg_b_reg : sat_add32(wm_reg[idx], 32'd1);
                    if (kind_reg == KIND_UNLINK) begin
                        if (age_next > UNLINK_WINDOW) begin
                            run_next = 3'd0;
                        end
                        if (run_next < RUN_MAX) begin
                            run_next = run_next + 3'd1;
                        end
                        age_next = 4'd0;
                        step     = {run_next, 1'b0};
                        if (step > UNLINK_CAP) begin
                            step = UNLINK_CAP;
                        end
                        bonus = step - UNLINK_BASE + (arg_a_reg[0] ? UNLINK_BASE : 4'd0);
                    end else if (age_next < AGE_MAX) begin
                        age_next = age_next + 4'd1;
                    end
                    fold_en  = 1'b1;
                    fold_add = 32'(scored_weight(kind_reg)) + 32'(bonus);
                end
            end
            KIND_NETCOMMIT: begin
                if (counted) begin
                    bytes_next = sat_add32(bytes_reg[idx], arg_b_reg);
                end
                if (is_local) begin
                    res_next.reply_first = DEC_COMMIT;
                end else if (arg_b_reg > {16'd0, send_lim_reg}) begin
                    res_next.reply_first = DEC_ABORT;
                end else if (counted && bytes_next > cum_lim_reg) begin
                    res_next.reply_first = DEC_ABORT;
                end
                eligible = scored && !is_local && bytes_next > exfil_lim_reg;
            end
            KIND_CURVATURE: begin
                eligible = scored && (arg_a_reg == 32'd1 || arg_a_reg == 32'd2);
            end
            KIND_DNS, KIND_MSYSCALL: begin
                eligible = scored;
            end
            KIND_TCP: begin
                eligible = scored && !is_local;
            end
            default: ;
        endcase

        // Single-fire promotion of the signature kinds.
        async_hit = eligible && !prom_reg[idx] && cb_en_reg;
        if (async_hit) begin
            prom_next = 1'b1;
            want_req  = 1'b1;
            fold_en   = 1'b1;
            if (age_next < AGE_MAX) begin
                age_next = age_next + 4'd1;
            end
            res_next.reply_first = DEC_SYNTH;
            if (kind_reg == KIND_NETCOMMIT) begin
                res_next.reply_second = TIER_TWO;
            end
        end

        if (fold_en) begin
            score_next = sat_add32(score_next, fold_add);
            if (score_next >= {16'd0, tier_two_reg}) begin
                target = TIER_TWO;
            end else if (score_next >= {16'd0, tier_one_reg}) begin
                target = TIER_ONE;
            end
            if (target > tier_next) begin
                tier_next = target;
                promoted  = target;
            end
        end

        if (!async_hit && promoted != TIER_NONE) begin
            want_req             = 1'b1;
            req_slot             = mstore_next;
            req_tier             = promoted;
            res_next.reply_first = promoted;
        end

        if (want_req && st_en_reg && req_slot != 32'd0) begin
            res_next.set_tier_valid = 1'b1;
            res_next.set_tier_slot  = req_slot;
            res_next.set_tier_value = req_tier;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < SLOT_COUNT; i++) begin
                score_reg[i]  <= '0;
                tier_reg[i]   <= TIER_NONE;
                wm_reg[i]     <= '0;
                mstore_reg[i] <= '0;
                prom_reg[i]   <= 1'b0;
                run_reg[i]    <= '0;
                age_reg[i]    <= '0;
                bytes_reg[i]  <= '0;
            end
        end else if (advance && counted) begin
            score_reg[idx]  <= score_next;
            tier_reg[idx]   <= tier_next;
            wm_reg[idx]     <= wm_next;
            mstore_reg[idx] <= mstore_next;
            prom_reg[idx]   <= prom_next;
            run_reg[idx]    <= run_next;
            age_reg[idx]    <= age_next;
            bytes_reg[idx]  <= bytes_next;
        end
    end

    // Result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance) begin
            out_valid_reg <= 1'b1;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            out_reg <= res_next;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {1'b0, out_reg.set_tier_value, out_reg.set_tier_slot,
                       out_reg.set_tier_valid, out_reg.reply_second, out_reg.reply_first};

`ifndef ASSERT_OFF
    // Slot zero is never scored, so its tier stays at none.
    assert property (@(posedge aclk) disable iff (!aresetn)
        tier_reg[0] == TIER_NONE)
        else $error("slot zero was promoted");

    // A set-tier request always names a slot and a real tier.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (out_valid_reg && out_reg.set_tier_valid) |->
        (out_reg.set_tier_slot != 32'd0 && out_reg.set_tier_value != TIER_NONE))
        else $error("set-tier request without slot or tier");

    // A second reply field is only given with a synthesized send.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (out_valid_reg && out_reg.reply_second != TIER_NONE) |->
        (out_reg.reply_first == DEC_SYNTH))
        else $error("promotion tier without synthesized decision");

    // The input side stalls only when both stages are full and the output is held.
    assert property (@(posedge aclk) disable iff (!aresetn)
        !s_tready |-> (in_valid_reg && out_valid_reg && !m_tready))
        else $error("input stalled without back-pressure");

    // Every processed event yields a result in the next cycle.
    assert property (@(posedge aclk) disable iff (!aresetn)
        advance |=> out_valid_reg)
        else $error("processed event produced no result");
`endif

endmodule

>>> tb/tb_top.sv
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import ppss_pkg::*;

    localparam int          SLOTS          = ppss_pkg::SLOT_COUNT;
    localparam int          LIMIT_CYCLES   = 300000;
    localparam int          EVENTS_PER_SET = 410;
    localparam logic [3:0]  KIND_AUDIT_TOP = 4'd15;
    // Unlink burst scoring: window of quiet events, bonus step and bonus ceiling.
    localparam logic [3:0]  BURST_WINDOW   = 4'd8;
    localparam logic [31:0] BURST_STEP     = 32'd2;
    localparam logic [31:0] BURST_CAP      = 32'd12;
    localparam logic [31:0] SAT32          = 32'hFFFF_FFFF;

    typedef enum int {READY_ALWAYS, READY_RANDOM, READY_PERIODIC} ready_style_t;
    typedef enum int {SEQ_SESSION, SEQ_RESPAWN, SEQ_NETWORK, SEQ_SIGNATURE, SEQ_NOISE} traffic_t;

    logic         aclk = 1'b0;
    logic         aresetn = 1'b0;
    logic         cfg_wen = 1'b0;
    logic [2:0]   cfg_index = '0;
    logic [31:0]  cfg_wdata = '0;
    logic         s_tvalid = 1'b0;
    logic         s_tready;
    logic [103:0] s_tdata = '0;
    logic [3:0]   s_tuser = '0;
    logic         m_tvalid;
    logic         m_tready = 1'b0;
    logic [39:0]  m_tdata;

    per_process_suspicion_scorer dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wen   (cfg_wen),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    always #2 aclk = ~aclk;

    // Scorer state as the block should hold it.
    logic [31:0] score_tab [SLOTS];
    logic [1:0]  tier_tab  [SLOTS];
    logic [31:0] water_tab [SLOTS];
    logic [31:0] mgr_tab   [SLOTS];
    logic        once_tab  [SLOTS];
    logic [2:0]  run_tab   [SLOTS];
    logic [3:0]  age_tab   [SLOTS];
    logic [31:0] bytes_tab [SLOTS];

    logic [15:0] cfg_t1, cfg_t2, cfg_send_lim;
    logic [7:0]  cfg_local;
    logic [31:0] cfg_cum_lim, cfg_exfil_lim;
    logic        cfg_cb_en, cfg_st_en;

    result_t expected_replies [$];

    int fail_count    = 0;
    int cycle_count   = 0;
    int events_sent   = 0;
    int acted_events  = 0;
    int replies_seen  = 0;
    int settings_used = 0;
    int promotions    = 0;
    int tier_requests = 0;
    int aborts        = 0;
    int synthesised   = 0;
    int burst_left    = 0;

    function automatic void clear_scorer();
        for (int i = 0; i < SLOTS; i++) begin
            score_tab[i] = '0;
            tier_tab[i]  = TIER_NONE;
            water_tab[i] = '0;
            mgr_tab[i]   = '0;
            once_tab[i]  = 1'b0;
            run_tab[i]   = '0;
            age_tab[i]   = '0;
            bytes_tab[i] = '0;
        end
        cfg_t1        = RST_TIER_ONE;
        cfg_t2        = RST_TIER_TWO;
        cfg_local     = RST_LOCAL_OCT;
        cfg_send_lim  = RST_SEND_LIM;
        cfg_cum_lim   = RST_CUM_LIM;
        cfg_exfil_lim = RST_EXFIL_LIM;
        cfg_cb_en     = 1'b0;
        cfg_st_en     = 1'b0;
    endfunction

    function automatic logic [31:0] sat_sum(input logic [31:0] a, input logic [63:0] b);
        logic [63:0] s;
        s = {32'd0, a} + b;
        return (s > {32'd0, SAT32}) ? SAT32 : s[31:0];
    endfunction

    function automatic void bump_age(input int s);
        if (age_tab[s] != 4'hF) age_tab[s] = age_tab[s] + 4'd1;
    endfunction

    // Adds the kind's weight plus any bonus and returns the newly reached tier, if any.
    function automatic logic [1:0] raise_score(input int s, input logic [3:0] kind,
                                               input logic [31:0] bonus);
        logic [31:0] weight;
        logic [1:0]  target;
        case (kind)
            KIND_WRITE:  weight = 32'd1;
            KIND_UNLINK: weight = 32'd2;
            KIND_EXEC:   weight = 32'd8;
            KIND_CRED:   weight = 32'd15;
            KIND_NETCOMMIT, KIND_CURVATURE, KIND_DNS, KIND_TCP, KIND_MSYSCALL:
                weight = {16'd0, cfg_t2};
            default:     weight = 32'd0;
        endcase
        score_tab[s] = sat_sum(score_tab[s], {32'd0, weight} + {32'd0, bonus});
        if (score_tab[s] >= {16'd0, cfg_t2}) target = TIER_TWO;
        else if (score_tab[s] >= {16'd0, cfg_t1}) target = TIER_ONE;
        else target = TIER_NONE;
        if (target > tier_tab[s]) begin
            tier_tab[s] = target;
            return target;
        end
        return TIER_NONE;
    endfunction

    function automatic void ask_tier(input int s, input logic [1:0] tier, inout result_t r);
        if (cfg_st_en && mgr_tab[s] != 0) begin
            r.set_tier_valid = 1'b1;
            r.set_tier_slot  = mgr_tab[s];
            r.set_tier_value = tier;
        end
    endfunction

    // The signature kinds may lift a slot to tier two only once per tenant.
    function automatic bit fire_signature(input int s, input logic [3:0] kind, inout result_t r);
        if (once_tab[s] || !cfg_cb_en) return 1'b0;
        once_tab[s] = 1'b1;
        ask_tier(s, TIER_TWO, r);
        void'(raise_score(s, kind, 32'd0));
        bump_age(s);
        return 1'b1;
    endfunction

    function automatic result_t predict_reply(input logic [3:0] kind, input logic [7:0] slot,
                                              input logic [31:0] a, input logic [31:0] b,
                                              input logic [31:0] mslot);
        result_t     r;
        int          s;
        bit          scored, counted, eligible;
        logic [31:0] bonus, step;
        logic [1:0]  target;
        logic [7:0]  octet;
        r       = '0;
        s       = int'(slot);
        scored  = (s >= 1) && (s < SLOTS);
        counted = s < SLOTS;
        octet   = a[7:0];
        if (kind <= KIND_CRED) begin
            if (scored) begin
                if (mslot != 0) mgr_tab[s] = mslot;
                // A falling write count means the slot has a new tenant.
                if (b != 0 && b < water_tab[s]) begin
                    score_tab[s] = '0;
                    tier_tab[s]  = TIER_NONE;
                    run_tab[s]   = '0;
                    age_tab[s]   = '0;
                    once_tab[s]  = 1'b0;
                end
                water_tab[s] = (b != 0) ? b : sat_sum(water_tab[s], 64'd1);
                bonus = '0;
                if (kind == KIND_UNLINK) begin
                    if (age_tab[s] > BURST_WINDOW) run_tab[s] = '0;
                    if (run_tab[s] != 3'd7) run_tab[s] = run_tab[s] + 3'd1;
                    age_tab[s] = '0;
                    step = BURST_STEP * {29'd0, run_tab[s]};
                    if (step > BURST_CAP) step = BURST_CAP;
                    bonus = step - BURST_STEP;
                    if (a[0]) bonus = bonus + BURST_STEP;
                end else begin
                    bump_age(s);
                end
                target = raise_score(s, kind, bonus);
                if (target != TIER_NONE) ask_tier(s, target, r);
                r.reply_first = target;
            end
        end else if (kind == KIND_NETCOMMIT) begin
            if (counted) bytes_tab[s] = sat_sum(bytes_tab[s], {32'd0, b});
            if (octet == cfg_local) r.reply_first = DEC_COMMIT;
            else if (b > {16'd0, cfg_send_lim}) r.reply_first = DEC_ABORT;
            else if (counted) begin
                if (bytes_tab[s] > cfg_cum_lim) r.reply_first = DEC_ABORT;
            end
            if (scored && octet != cfg_local) begin
                if (bytes_tab[s] > cfg_exfil_lim) begin
                    if (fire_signature(s, kind, r)) begin
                        r.reply_first  = DEC_SYNTH;
                        r.reply_second = TIER_TWO;
                    end
                end
            end
        end else if (kind <= KIND_MSYSCALL) begin
            eligible = scored;
            if (kind == KIND_CURVATURE && (a < 32'd1 || a > 32'd2)) eligible = 1'b0;
            if (kind == KIND_TCP && octet == cfg_local) eligible = 1'b0;
            if (eligible) begin
                if (fire_signature(s, kind, r)) r.reply_first = TIER_TWO;
            end
        end
        return r;
    endfunction

    // Event sender: bursts of random length separated by random gaps.
    task automatic send_event(input logic [3:0] kind, input logic [7:0] slot,
                              input logic [31:0] a, input logic [31:0] b,
                              input logic [31:0] mslot);
        int      gap;
        result_t r;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 32);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            if (gap > 0) begin
                @(negedge aclk);
                s_tvalid = 1'b0;
                repeat (gap - 1) @(negedge aclk);
            end
        end
        burst_left--;
        @(negedge aclk);
        s_tvalid = 1'b1;
        s_tuser  = kind;
        s_tdata  = {mslot, b, a, slot};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        r = predict_reply(kind, slot, a, b, mslot);
        expected_replies.push_back(r);
        events_sent++;
        if (kind == KIND_NETCOMMIT || (kind <= KIND_MSYSCALL && slot >= 1 && slot < SLOTS))
            acted_events++;
        if (r.set_tier_valid) tier_requests++;
        if (kind == KIND_NETCOMMIT) begin
            if (r.reply_first == DEC_ABORT) aborts++;
            if (r.reply_first == DEC_SYNTH) begin
                synthesised++;
                promotions++;
            end
        end else if (r.reply_first != TIER_NONE) begin
            promotions++;
        end
    endtask

    // Drops valid and lets the block drain before any register is touched.
    task automatic settle();
        @(negedge aclk);
        s_tvalid   = 1'b0;
        burst_left = 0;
        while (expected_replies.size() != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    task automatic write_reg(input logic [2:0] idx, input logic [31:0] value);
        @(negedge aclk);
        cfg_wen   = 1'b1;
        cfg_index = idx;
        cfg_wdata = value;
        @(negedge aclk);
        cfg_wen = 1'b0;
        case (idx)
            REG_TIER_ONE:  cfg_t1        = value[15:0];
            REG_TIER_TWO:  cfg_t2        = value[15:0];
            REG_LOCAL_OCT: cfg_local     = value[7:0];
            REG_SEND_LIM:  cfg_send_lim  = value[15:0];
            REG_CUM_LIM:   cfg_cum_lim   = value;
            REG_EXFIL_LIM: cfg_exfil_lim = value;
            REG_CB_EN:     cfg_cb_en     = value[0];
            REG_ST_EN:     cfg_st_en     = value[0];
            default: ;
        endcase
    endtask

    task automatic apply_settings(input logic [15:0] t1, input logic [15:0] t2,
                                  input logic [7:0] local_oct, input logic [15:0] send_lim,
                                  input logic [31:0] cum_lim, input logic [31:0] exfil_lim,
                                  input logic cb_en, input logic st_en);
        settle();
        write_reg(REG_TIER_ONE, {16'd0, t1});
        write_reg(REG_TIER_TWO, {16'd0, t2});
        write_reg(REG_LOCAL_OCT, {24'd0, local_oct});
        write_reg(REG_SEND_LIM, {16'd0, send_lim});
        write_reg(REG_CUM_LIM, cum_lim);
        write_reg(REG_EXFIL_LIM, exfil_lim);
        write_reg(REG_CB_EN, {31'd0, cb_en});
        write_reg(REG_ST_EN, {31'd0, st_en});
        settings_used++;
    endtask

    function automatic logic [31:0] next_count(input int s);
        if ($urandom_range(0, 11) == 0) return 32'd0;
        return sat_sum(water_tab[s], {32'd0, $urandom_range(0, 3)});
    endfunction

    // One tenant's run of scored events, optionally starting with a fall in the write count.
    task automatic tenant_session(input bit respawn);
        int          s, n, unlink_pct;
        logic [3:0]  kind;
        logic [31:0] count, mslot;
        s          = $urandom_range(1, SLOTS - 1);
        n          = $urandom_range(4, 20);
        unlink_pct = $urandom_range(0, 80);
        for (int i = 0; i < n; i++) begin
            if ($urandom_range(0, 99) < unlink_pct) kind = KIND_UNLINK;
            else kind = 4'($urandom_range(KIND_WRITE, KIND_CRED));
            if (i == 0 && respawn && water_tab[s] > 32'd1)
                count = $urandom_range(1, water_tab[s] - 1);
            else
                count = next_count(s);
            case ($urandom_range(0, 5))
                0:       mslot = $urandom;
                1:       mslot = $urandom_range(1, 64);
                default: mslot = '0;
            endcase
            send_event(kind, 8'(s), $urandom, count, mslot);
        end
    endtask

    task automatic network_burst();
        int          n;
        logic [7:0]  slot, octet;
        logic [31:0] len;
        slot = ($urandom_range(0, 4) == 0) ? 8'($urandom_range(SLOTS, 255))
                                           : 8'($urandom_range(0, SLOTS - 1));
        n = $urandom_range(1, 6);
        for (int i = 0; i < n; i++) begin
            octet = ($urandom_range(0, 3) == 0) ? cfg_local : 8'($urandom);
            case ($urandom_range(0, 9))
                0:          len = $urandom;
                1, 2, 3:    len = $urandom_range(0, 4000);
                default:    len = $urandom_range(0, 400);
            endcase
            send_event(KIND_NETCOMMIT, slot, {24'($urandom_range(0, 32'hFF_FFFF)), octet},
                       len, $urandom_range(0, 15));
        end
    endtask

    task automatic signature_burst();
        int          n;
        logic [3:0]  kind;
        logic [7:0]  slot;
        logic [31:0] a;
        n = $urandom_range(1, 4);
        for (int i = 0; i < n; i++) begin
            kind = 4'($urandom_range(KIND_CURVATURE, KIND_MSYSCALL));
            slot = ($urandom_range(0, 7) == 0) ? 8'($urandom)
                                               : 8'($urandom_range(0, SLOTS - 1));
            if (kind == KIND_CURVATURE && $urandom_range(0, 3) != 0)
                a = $urandom_range(0, 3);
            else if (kind == KIND_TCP && $urandom_range(0, 2) == 0)
                a = {24'($urandom_range(0, 32'hFF_FFFF)), cfg_local};
            else
                a = $urandom;
            send_event(kind, slot, a, $urandom, $urandom);
        end
    endtask

    task automatic noise_event();
        send_event(4'($urandom_range(0, KIND_AUDIT_TOP)), 8'($urandom), $urandom, $urandom,
                   $urandom);
    endtask

    // Mostly well-formed per-tenant sequences, with network, signature and noise traffic mixed in.
    task automatic run_traffic(input int events);
        int       goal;
        traffic_t pick;
        int       roll;
        goal = acted_events + events;
        while (acted_events < goal) begin
            roll = $urandom_range(0, 99);
            if (roll < 40) pick = SEQ_SESSION;
            else if (roll < 52) pick = SEQ_RESPAWN;
            else if (roll < 72) pick = SEQ_NETWORK;
            else if (roll < 87) pick = SEQ_SIGNATURE;
            else pick = SEQ_NOISE;
            case (pick)
                SEQ_SESSION:   tenant_session(1'b0);
                SEQ_RESPAWN:   tenant_session(1'b1);
                SEQ_NETWORK:   network_burst();
                SEQ_SIGNATURE: signature_burst();
                default:       noise_event();
            endcase
        end
    endtask

    task automatic test_reset_defaults();
        settings_used++;
        // Slot one climbs to tier one and then tier two through an unlink.
        send_event(KIND_WRITE,  8'd1, 32'd0, 32'd1, 32'h0000_1234);
        send_event(KIND_CRED,   8'd1, 32'd0, 32'd2, 32'd0);
        send_event(KIND_EXEC,   8'd1, 32'd0, 32'd3, 32'd0);
        send_event(KIND_CRED,   8'd1, 32'd0, 32'd4, 32'd0);
        send_event(KIND_UNLINK, 8'd1, 32'd1, 32'd5, 32'd0);
        send_event(KIND_AUDIT_TOP, 8'd1, SAT32, SAT32, SAT32);
        send_event(KIND_WRITE,  8'd0, 32'd0, 32'd9, 32'd7);
        send_event(KIND_EXEC,   8'hFF, 32'd0, 32'd9, 32'd7);
        send_event(KIND_NETCOMMIT, 8'd0, 32'h0000_000A, 32'd100, 32'd0);
        send_event(KIND_NETCOMMIT, 8'd200, 32'hFFFF_FF01, 32'd300, 32'd0);
        send_event(KIND_CURVATURE, 8'd3, 32'd1, 32'd0, 32'd0);
    endtask

    task automatic test_register_effects();
        apply_settings(16'd5, 16'd10, 8'hFF, 16'd0, 32'd0, 32'd1000, 1'b1, 1'b1);
        send_event(KIND_TCP, 8'd4, 32'h0000_00FF, 32'd0, 32'd0);
        send_event(KIND_TCP, 8'd4, 32'h0000_0001, 32'd0, 32'd0);
        send_event(KIND_NETCOMMIT, 8'd5, 32'h0000_00FF, 32'd0, 32'd0);
        send_event(KIND_NETCOMMIT, 8'd5, 32'h0000_0007, 32'd1, 32'd0);
        // Set-tier requests name the stored manager slot; a falling count then clears the slot.
        send_event(KIND_EXEC, 8'd6, 32'd0, 32'd11, SAT32);
        send_event(KIND_CRED, 8'd6, 32'd0, 32'd12, 32'd0);
        send_event(KIND_CURVATURE, 8'd6, 32'd2, 32'd0, 32'd0);
        send_event(KIND_WRITE, 8'd6, 32'd0, 32'd3, 32'd0);
        send_event(KIND_WRITE, 8'd7, 32'd0, SAT32, 32'd0);
        send_event(KIND_WRITE, 8'd7, 32'd0, 32'd0, 32'd0);
        send_event(KIND_NETCOMMIT, 8'd8, 32'h0000_0007, SAT32, 32'd0);
        send_event(KIND_NETCOMMIT, 8'd8, 32'h0000_0007, SAT32, 32'd0);
        send_event(KIND_MSYSCALL, 8'd9, 32'd0, 32'd0, 32'd0);
        send_event(KIND_DNS, 8'd10, 32'd0, 32'd0, 32'd0);
        send_event(KIND_CURVATURE, 8'd11, 32'd3, 32'd0, 32'd0);
    endtask

    task automatic test_traffic_nominal();
        apply_settings(RST_TIER_ONE, RST_TIER_TWO, RST_LOCAL_OCT, RST_SEND_LIM, RST_CUM_LIM,
                       RST_EXFIL_LIM, 1'b1, 1'b1);
        run_traffic(EVENTS_PER_SET);
    endtask

    task automatic test_traffic_extremes();
        apply_settings(16'd0, 16'd0, 8'd0, 16'd0, 32'd0, 32'd0, 1'b1, 1'b1);
        run_traffic(EVENTS_PER_SET / 2);
        apply_settings(16'hFFFF, 16'hFFFF, 8'hFF, 16'hFFFF, SAT32, SAT32, 1'b1, 1'b0);
        run_traffic(EVENTS_PER_SET / 2);
    endtask

    task automatic test_traffic_crossed_thresholds();
        apply_settings(16'd60, 16'd25, 8'd192, 16'd512, 32'd8000, 32'd20000, 1'b1, 1'b1);
        run_traffic(EVENTS_PER_SET);
    endtask

    task automatic test_traffic_random_settings();
        for (int i = 0; i < 2; i++) begin
            apply_settings(16'($urandom_range(0, 100)), 16'($urandom_range(0, 100)),
                           8'($urandom), 16'($urandom_range(0, 1000)),
                           $urandom_range(0, 20000), $urandom_range(0, 60000),
                           1'($urandom), ($urandom_range(0, 3) != 0));
            run_traffic(EVENTS_PER_SET / 2);
        end
    endtask

    // Result receiver: switches between always ready, random stalls and a fixed duty pattern.
    ready_style_t ready_style = READY_ALWAYS;
    int           style_left  = 0;
    int           duty_count  = 0;

    always @(negedge aclk) begin
        if (style_left == 0) begin
            ready_style = ready_style_t'($urandom_range(READY_ALWAYS, READY_PERIODIC));
            style_left  = $urandom_range(32, 200);
        end
        style_left--;
        duty_count++;
        case (ready_style)
            READY_ALWAYS: m_tready = 1'b1;
            READY_RANDOM: m_tready = 1'($urandom);
            default:      m_tready = (duty_count % 5) < 2;
        endcase
    end

    function automatic void compare_field(input string name, input logic [31:0] want,
                                          input logic [31:0] got);
        if (want !== got) begin
            $error("%s mismatch: expected %0d, got %0d", name, want, got);
            fail_count++;
        end
    endfunction

    always @(posedge aclk) begin : check_replies
        result_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (expected_replies.size() == 0) begin
                $error("result transaction with no event outstanding: m_tdata=%h", m_tdata);
                fail_count++;
            end else begin
                want = expected_replies.pop_front();
                compare_field("reply_first", {30'd0, want.reply_first}, {30'd0, m_tdata[1:0]});
                compare_field("reply_second", {30'd0, want.reply_second},
                              {30'd0, m_tdata[3:2]});
                compare_field("set_tier_valid", {31'd0, want.set_tier_valid},
                              {31'd0, m_tdata[4]});
                compare_field("set_tier_slot", want.set_tier_slot, m_tdata[36:5]);
                compare_field("set_tier_value", {30'd0, want.set_tier_value},
                              {30'd0, m_tdata[38:37]});
                replies_seen++;
            end
        end
    end

    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count >= LIMIT_CYCLES) begin
            $display("Timed out with %0d results outstanding.", expected_replies.size());
            $display("CHECKS FAILED");
            $finish;
        end
    end

    initial begin
        clear_scorer();
        repeat (5) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        test_reset_defaults();
        test_register_effects();
        test_traffic_nominal();
        test_traffic_extremes();
        test_traffic_crossed_thresholds();
        test_traffic_random_settings();

        settle();
        repeat (8) @(posedge aclk);
        $display("Sent %0d events (%0d acted on) under %0d register settings; %0d results checked.",
                 events_sent, acted_events, settings_used, replies_seen);
        $display("Expected %0d promotions, %0d set-tier requests, %0d aborts, %0d synthesised.",
                 promotions, tier_requests, aborts, synthesised);
        if (fail_count == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule
